// ===== design/chh_pkg.sv =====
// ----------------------------------------------------------------------------
// Character n-gram hasher package
// Shared constants, configuration codes and byte helpers.
// ----------------------------------------------------------------------------
package chh_pkg;

  localparam int DEF_MAX_WORD_BYTES = 16;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [24:0] BUCKET_MAX = 25'd16777216;

  localparam logic [7:0] OPEN_MARK  = 8'h3C;
  localparam logic [7:0] CLOSE_MARK = 8'h3E;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd2;

  localparam logic [2:0]  RST_MIN_LEN      = 3'd3;
  localparam logic [2:0]  RST_MAX_LEN      = 3'd6;
  localparam logic [24:0] RST_BUCKET_COUNT = 25'd2000000;

  localparam logic [2:0] LEN_LO = 3'd3;
  localparam logic [2:0] LEN_HI = 3'd6;

  // Byte length of a UTF-8 character from its lead byte.
  function automatic logic [2:0] lead_char_bytes(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if ((b & 8'h80) == 8'h00) len = 3'd1;
    else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    return len;
  endfunction

  function automatic logic [2:0] clamp_len(input logic [2:0] v);
    logic [2:0] r;
    r = v;
    if (v < LEN_LO) r = LEN_LO;
    else if (v > LEN_HI) r = LEN_HI;
    return r;
  endfunction

endpackage

// ===== design/chh_in_if.sv =====
// ----------------------------------------------------------------------------
// Word byte channel
// Valid/ready channel carrying one word byte and its end marker per beat.
// ----------------------------------------------------------------------------
interface chh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] word_byte;
  logic       word_end;

  modport source (output valid, output word_byte, output word_end, input ready);
  modport sink   (input valid, input word_byte, input word_end, output ready);
endinterface

// ===== design/chh_out_if.sv =====
// ----------------------------------------------------------------------------
// N-gram result channel
// Valid/ready channel carrying one hashed n-gram per beat.
// ----------------------------------------------------------------------------
interface chh_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] bucket;
  logic [31:0] full_hash;
  logic [2:0]  gram_len;
  logic [4:0]  start_char;
  logic        truncated;
  logic        no_gram;
  logic        last;

  modport source (output valid, output bucket, output full_hash, output gram_len,
                  output start_char, output truncated, output no_gram, output last,
                  input ready);
  modport sink   (input valid, input bucket, input full_hash, input gram_len,
                  input start_char, input truncated, input no_gram, input last,
                  output ready);
endinterface

// ===== design/chh_front.sv =====
// ----------------------------------------------------------------------------
// Word collector
// Stores word bytes, flags overflow and hands each finished word to the queue.
// ----------------------------------------------------------------------------
module chh_front #(
  parameter int MAX_WORD_BYTES = chh_pkg::DEF_MAX_WORD_BYTES,
  parameter int CNT_W          = $clog2(MAX_WORD_BYTES + 1),
  parameter int JOB_W          = MAX_WORD_BYTES * 8 + CNT_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  chh_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             q_push,
  output logic [JOB_W-1:0] q_data
);
  import chh_pkg::*;

  localparam int BI_W = $clog2(MAX_WORD_BYTES);

  logic [MAX_WORD_BYTES-1:0][7:0] store_r;
  logic [MAX_WORD_BYTES-1:0][7:0] store_nxt;
  logic [CNT_W-1:0]               cnt_r;
  logic [CNT_W-1:0]               cnt_nxt;
  logic                           ovf_r;
  logic                           ovf_nxt;
  logic                           accept;
  logic                           room;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = cnt_r < CNT_W'(MAX_WORD_BYTES);

  always_comb begin
    store_nxt = store_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    if (room) begin
      store_nxt[cnt_r[BI_W-1:0]] = in_ch.word_byte;
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign q_push = accept && in_ch.word_end;
  assign q_data = {store_nxt, cnt_nxt, ovf_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      if (in_ch.word_end) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r <= store_nxt;
    end
  end

endmodule

// ===== design/chh_queue.sv =====
// ----------------------------------------------------------------------------
// Word queue
// Two-entry queue of finished words between the collector and the hasher.
// ----------------------------------------------------------------------------
module chh_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  logic [1:0][W-1:0] ent_r;
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_data  = ent_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/chh_mod.sv =====
// ----------------------------------------------------------------------------
// Bucket reducer
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module chh_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [24:0] divisor,
  output logic        done,
  output logic [23:0] rem
);

  logic [31:0] sh_r;
  logic [24:0] rem_r;
  logic [24:0] div_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [25:0] trial;
  logic [25:0] diff;

  assign trial = {rem_r, sh_r[31]};
  assign diff  = trial - {1'b0, div_r};
  assign done  = done_r;
  assign rem   = rem_r[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      sh_r <= {sh_r[30:0], 1'b0};
      if (trial >= {1'b0, div_r}) rem_r <= diff[24:0];
      else rem_r <= trial[24:0];
    end
  end

endmodule

// ===== design/chh_back.sv =====
// ----------------------------------------------------------------------------
// N-gram engine
// Splits a queued word into characters, walks every n-gram, hashes it byte
// by byte and reduces it to a bucket.
// ----------------------------------------------------------------------------
module chh_back #(
  parameter int MAX_WORD_BYTES = chh_pkg::DEF_MAX_WORD_BYTES,
  parameter int CNT_W          = $clog2(MAX_WORD_BYTES + 1),
  parameter int JOB_W          = MAX_WORD_BYTES * 8 + CNT_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  logic [JOB_W-1:0] job_data,
  output logic             job_pop,
  input  logic [2:0]       cfg_min_len,
  input  logic [2:0]       cfg_max_len,
  input  logic [24:0]      cfg_bucket_count,
  chh_out_if.source        out_ch
);
  import chh_pkg::*;

  localparam int WRAP  = MAX_WORD_BYTES + 2;
  localparam int POS_W = $clog2(WRAP + 1);
  localparam int IDX_W = $clog2(WRAP);
  localparam int BI_W  = $clog2(MAX_WORD_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_CHECK, ST_SETUP, ST_HASH, ST_DIV, ST_EMIT
  } state_t;

  state_t state_r;

  logic [MAX_WORD_BYTES-1:0][7:0] job_bytes;
  logic [CNT_W-1:0]               job_cnt;
  logic                           job_trunc;

  logic [WRAP-1:0][POS_W-1:0] cstart_r;
  logic [WRAP:0]              is_start_r;
  logic [POS_W-1:0]           p_r;
  logic [POS_W-1:0]           wlen_r;
  logic [POS_W-1:0]           nch_r;
  logic [POS_W-1:0]           s_r;
  logic [2:0]                 n_r;
  logic [2:0]                 hi_r;
  logic [2:0]                 seen_r;
  logic [31:0]                h_r;
  logic                       ng_r;

  logic                       out_valid_r;
  logic [23:0]                bucket_r;
  logic [31:0]                hash_r;
  logic [2:0]                 len_r;
  logic [4:0]                 start_r;
  logic                       trunc_r;
  logic                       no_gram_r;
  logic                       last_r;

  logic [7:0]       wb;
  logic [POS_W-1:0] bidx;
  logic [POS_W:0]   char_end;
  logic [POS_W:0]   char_end_clip;
  logic [2:0]       lo;
  logic [2:0]       hi;
  logic [31:0]      h_nxt;
  logic             hash_stop;
  logic [24:0]      mod_eff;
  logic             div_start;
  logic             div_done;
  logic [23:0]      div_rem;
  logic             out_free;
  logic             more_s;
  logic             more_n;
  logic             is_last;

  assign {job_bytes, job_cnt, job_trunc} = job_data;

  // Byte p of the word as wrapped in its markers.
  assign bidx = p_r - POS_W'(1);
  always_comb begin
    if (p_r == '0) wb = OPEN_MARK;
    else if (p_r == wlen_r - POS_W'(1)) wb = CLOSE_MARK;
    else wb = job_bytes[bidx[BI_W-1:0]];
  end

  assign char_end      = {1'b0, p_r} + (POS_W + 1)'(lead_char_bytes(wb));
  assign char_end_clip = (char_end > {1'b0, wlen_r}) ? {1'b0, wlen_r} : char_end;

  assign lo = clamp_len(cfg_min_len);
  assign hi = clamp_len(cfg_max_len);

  always_comb begin
    if (cfg_bucket_count == '0) mod_eff = 25'd1;
    else if (cfg_bucket_count > BUCKET_MAX) mod_eff = BUCKET_MAX;
    else mod_eff = cfg_bucket_count;
  end

  assign h_nxt     = 32'((h_r ^ {{24{wb[7]}}, wb}) * FNV_PRIME);
  assign hash_stop = (p_r == wlen_r) || (is_start_r[p_r] && seen_r == n_r);
  assign div_start = (state_r == ST_HASH) && hash_stop;

  assign out_free = !out_valid_r || out_ch.ready;
  assign more_s   = ({1'b0, s_r} + (POS_W + 1)'(n_r) + (POS_W + 1)'(1)) <= {1'b0, nch_r};
  assign more_n   = (n_r < hi_r) && ((POS_W + 1)'(n_r) + (POS_W + 1)'(1) <= {1'b0, nch_r});
  assign is_last  = ng_r || (!more_s && !more_n);
  assign job_pop  = (state_r == ST_EMIT) && out_free && is_last;

  chh_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (h_r),
    .divisor  (mod_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bucket     = bucket_r;
  assign out_ch.full_hash  = hash_r;
  assign out_ch.gram_len   = len_r;
  assign out_ch.start_char = start_r;
  assign out_ch.truncated  = trunc_r;
  assign out_ch.no_gram    = no_gram_r;
  assign out_ch.last       = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_EMIT) && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            p_r        <= '0;
            nch_r      <= '0;
            is_start_r <= '0;
            wlen_r     <= POS_W'(job_cnt) + POS_W'(2);
            ng_r       <= 1'b0;
            state_r    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cstart_r[nch_r[IDX_W-1:0]] <= p_r;
          is_start_r[p_r]            <= 1'b1;
          nch_r                      <= nch_r + POS_W'(1);
          p_r                        <= char_end_clip[POS_W-1:0];
          if (char_end_clip == {1'b0, wlen_r}) state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          n_r  <= lo;
          hi_r <= hi;
          s_r  <= '0;
          if (hi < lo || POS_W'(lo) > nch_r) begin
            ng_r    <= 1'b1;
            h_r     <= '0;
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          p_r     <= cstart_r[s_r[IDX_W-1:0]];
          h_r     <= FNV_BASIS;
          seen_r  <= '0;
          state_r <= ST_HASH;
        end
        ST_HASH: begin
          if (hash_stop) begin
            state_r <= ST_DIV;
          end else begin
            if (is_start_r[p_r]) seen_r <= seen_r + 3'd1;
            h_r <= h_nxt;
            p_r <= p_r + POS_W'(1);
          end
        end
        ST_DIV: begin
          if (div_done) state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            trunc_r     <= job_trunc;
            no_gram_r   <= ng_r;
            last_r      <= is_last;
            if (ng_r) begin
              bucket_r <= '0;
              hash_r   <= '0;
              len_r    <= '0;
              start_r  <= '0;
            end else begin
              bucket_r <= div_rem;
              hash_r   <= h_r;
              len_r    <= n_r;
              start_r  <= 5'(s_r);
            end
            if (is_last) begin
              state_r <= ST_IDLE;
            end else if (more_s) begin
              s_r     <= s_r + POS_W'(1);
              state_r <= ST_SETUP;
            end else begin
              n_r     <= n_r + 3'd1;
              s_r     <= '0;
              state_r <= ST_SETUP;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_nogram_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.no_gram) |-> (out_ch.last && out_ch.full_hash == '0))
    else $error("no-gram result must be the word's only, zeroed beat");

  a_hash_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HASH) |-> (p_r <= wlen_r))
    else $error("hash pointer ran past the wrapped word");

  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.no_gram) |-> ({1'b0, out_ch.bucket} < mod_eff))
    else $error("bucket not below the modulus");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (out_ch.valid && out_ch.last))
    else $error("word released without its final beat");
`endif

endmodule

// ===== design/char_ngram_subword_hasher.sv =====
// ----------------------------------------------------------------------------
// Character n-gram subword hasher
// Collects words byte by byte and emits the hashed character n-grams of each.
// ----------------------------------------------------------------------------
//  channel  direction  beat
//  in_ch    in         one word byte, word_end on the final byte
//  out_ch   out        one n-gram: bucket, full_hash, length, start, flags
//  cfg_*    in         register write, no handshake
//
// A byte is taken every cycle while the two-entry word queue has room.
// Per word: the engine takes it from the queue, splits it into characters and
// checks the length range. Each n-gram then has a setup step, is hashed byte by
// byte with a finishing step, waits on the bit-serial remainder unit and loads
// the output register.
// Reset is synchronous and clears control state only; a held-off out_ch stalls
// the engine at its output register, and a full queue then stalls in_ch.
module char_ngram_subword_hasher #(
  parameter int MAX_WORD_BYTES = chh_pkg::DEF_MAX_WORD_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  chh_in_if.sink                         in_ch,
  chh_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [chh_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [chh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import chh_pkg::*;

  localparam int CNT_W = $clog2(MAX_WORD_BYTES + 1);
  localparam int JOB_W = MAX_WORD_BYTES * 8 + CNT_W + 1;

  logic [2:0]       min_len_r;
  logic [2:0]       max_len_r;
  logic [24:0]      bucket_count_r;
  logic             q_full;
  logic             q_push;
  logic [JOB_W-1:0] q_data;
  logic             q_pop;
  logic             q_valid;
  logic [JOB_W-1:0] q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r      <= RST_MIN_LEN;
      max_len_r      <= RST_MAX_LEN;
      bucket_count_r <= RST_BUCKET_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_LEN:      min_len_r      <= cfg_data[2:0];
        CFG_MAX_LEN:      max_len_r      <= cfg_data[2:0];
        CFG_BUCKET_COUNT: bucket_count_r <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  chh_front #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES),
    .CNT_W          (CNT_W),
    .JOB_W          (JOB_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  chh_queue #(
    .W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  chh_back #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES),
    .CNT_W          (CNT_W),
    .JOB_W          (JOB_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_valid),
    .job_data         (q_head),
    .job_pop          (q_pop),
    .cfg_min_len      (min_len_r),
    .cfg_max_len      (max_len_r),
    .cfg_bucket_count (bucket_count_r),
    .out_ch           (out_ch)
  );

endmodule
